FILE: src/fscl_pkg.sv
// Shared constants, types and helpers for the frame-synced control-voltage looper.
`default_nettype none

package fscl_pkg;

    // Parameter defaults
    localparam int STORE_DEPTH_DEF       = 256;
    localparam int MAX_RECORD_FRAMES_DEF = 251;
    localparam int SAMPLE_BITS_DEF       = 10;

    // Fixed field widths
    localparam int LEVEL_W = 8;
    localparam int POS_W   = 8;
    localparam int REF_W   = 10;
    localparam int MODE_W  = 2;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;
    localparam logic [REF_W-1:0]   REF_RESET  = 10'd930;

    // Drive mode codes
    localparam logic [MODE_W-1:0] MODE_LOW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HIGH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PWM  = 2'd2;

    // Divider status handed to the sequencer
    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } div_res_t;

    // Reduce a frame position modulo the store depth by conditional subtraction
    function automatic logic [POS_W-1:0] slot_of(input logic [POS_W-1:0] pos, input int depth);
        logic [2*POS_W-1:0] v;
        logic [2*POS_W-1:0] d;
        v = {{POS_W{1'b0}}, pos};
        for (int k = POS_W - 1; k >= 0; k--) begin
            d = 16'(depth) << k;
            if (v >= d) begin
                v = v - d;
            end
        end
        return v[POS_W-1:0];
    endfunction

    // Map a played level to its pin drive mode
    function automatic logic [MODE_W-1:0] mode_of(input logic [LEVEL_W-1:0] lvl);
        if (lvl == '0) begin
            return MODE_LOW;
        end else if (lvl == FULL_LEVEL) begin
            return MODE_HIGH;
        end else begin
            return MODE_PWM;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/fscl_div.sv
// Bit-serial restoring divider that scales a sample to min(sample*255/ref, 255).
`default_nettype none

module fscl_div
    import fscl_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic [REF_W-1:0]       den,
    output div_res_t                    res
);

    localparam int NUM_W = SAMPLE_BITS + LEVEL_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]   num_reg, num_next;
    logic [REF_W-1:0]   rem_reg, rem_next;
    logic [REF_W-1:0]   den_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               zero_reg;
    logic [LEVEL_W-1:0] level_reg;

    logic [REF_W:0]     trial;
    logic [REF_W:0]     diff;
    logic               ge;
    logic               sat;
    logic [NUM_W-1:0]   product;

    // Form sample*255 as a shift and a subtract
    assign product = {sample, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, sample};

    // One quotient bit per cycle
    always_comb begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[REF_W-1:0] : trial[REF_W-1:0];
        num_next = {num_reg[NUM_W-2:0], ge};
        sat      = zero_reg || (|num_next[NUM_W-1:LEVEL_W]);
    end

    // Control: load on start, count down, pulse done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= product;
            rem_reg  <= '0;
            den_reg  <= den;
            zero_reg <= (den == '0);
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            if (cnt_reg == CNT_W'(1)) begin
                level_reg <= sat ? FULL_LEVEL : num_next[LEVEL_W-1:0];
            end
        end
    end

    assign res.done  = done_reg;
    assign res.level = level_reg;

endmodule

`default_nettype wire

FILE: src/frame_synced_cv_looper_top.sv
// Frame-synced control-voltage looper: per-frame record/playback of a scaled CV level.
// Each transaction is scaled by SAMPLE_BITS+8 divider steps at one quotient bit per cycle,
//   then the sequencer writes back and presents the result.
// One transaction is in flight at a time; input is held off while busy and
//   while a finished result waits for the output register to free up.
// Reset: synchronous, active low; clears position, loop end, record flag, store valid bits,
//   and loads the full-scale reference with 930. Store entries read as zero until written.
`default_nettype none

module frame_synced_cv_looper_top
    import fscl_pkg::*;
#(
    parameter int STORE_DEPTH       = STORE_DEPTH_DEF,
    parameter int MAX_RECORD_FRAMES = MAX_RECORD_FRAMES_DEF,
    parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [REF_W-1:0]       cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_record_button,
    input  wire logic [SAMPLE_BITS-1:0] s_cv_sample,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [LEVEL_W-1:0]          m_level,
    output logic [MODE_W-1:0]           m_drive_mode,
    output logic [POS_W-1:0]            m_loop_position,
    output logic                        m_recording
);

    localparam int SLOT_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [REF_W-1:0]   ref_reg;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   loop_end_reg, loop_end_next;
    logic               was_rec_reg, was_rec_next;
    logic               rec_reg, rec_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [LEVEL_W-1:0] store_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] vld_reg;
    logic [LEVEL_W-1:0] rd_data_reg;
    logic               rd_vld_reg;
    logic               m_valid_reg;
    logic [LEVEL_W-1:0] m_level_reg;
    logic [MODE_W-1:0]  m_mode_reg;
    logic [POS_W-1:0]   m_pos_reg;
    logic               m_rec_reg;

    logic               in_xact;
    logic               out_free;
    logic               finish;
    logic [POS_W-1:0]   pos_inc;
    logic [LEVEL_W-1:0] lvl;
    div_res_t           div_res;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_xact   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign finish    = (state_reg == ST_FINISH) && out_free;
    assign pos_inc   = pos_reg + 1'b1;

    // Shared scaling unit
    fscl_div #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (in_xact),
        .sample (s_cv_sample),
        .den    (ref_reg),
        .res    (div_res)
    );

    // Track button edges, loop end and position for the incoming frame
    always_comb begin
        pos_next      = pos_reg;
        loop_end_next = loop_end_reg;
        was_rec_next  = was_rec_reg;
        rec_next      = s_record_button;
        if (s_record_button != was_rec_reg) begin
            loop_end_next = was_rec_reg ? pos_inc : POS_W'(MAX_RECORD_FRAMES);
            pos_next      = '0;
            was_rec_next  = s_record_button;
        end else if (pos_inc >= loop_end_reg) begin
            if (s_record_button) begin
                rec_next      = 1'b0;
                was_rec_next  = 1'b0;
                loop_end_next = pos_inc;
            end
            pos_next = '0;
        end else begin
            pos_next = pos_inc;
        end
    end

    // Sequence: accept, divide, then write back and present
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_xact) state_next = ST_BUSY;
            ST_BUSY:   if (div_res.done) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ref_reg      <= REF_RESET;
            pos_reg      <= '0;
            loop_end_reg <= '0;
            was_rec_reg  <= 1'b0;
            rec_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            vld_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                ref_reg <= cfg_data;
            end
            if (in_xact) begin
                pos_reg      <= pos_next;
                loop_end_reg <= loop_end_next;
                was_rec_reg  <= was_rec_next;
                rec_reg      <= rec_next;
            end
            if (finish && rec_reg) begin
                vld_reg[slot_reg] <= 1'b1;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Store: slot from position, registered read, write on a recorded frame
    always_ff @(posedge aclk) begin
        slot_reg    <= SLOT_W'(slot_of(pos_reg, STORE_DEPTH));
        rd_data_reg <= store_mem[slot_reg];
        rd_vld_reg  <= vld_reg[slot_reg];
        if (finish && rec_reg) begin
            store_mem[slot_reg] <= div_res.level;
        end
    end

    // Pick the played level: fresh sample when recording, else stored entry, or zero if never written
    always_comb begin
        if (rec_reg) begin
            lvl = div_res.level;
        end else if (rd_vld_reg) begin
            lvl = rd_data_reg;
        end else begin
            lvl = '0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (finish) begin
            m_level_reg <= lvl;
            m_mode_reg  <= mode_of(lvl);
            m_pos_reg   <= pos_reg;
            m_rec_reg   <= rec_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_level         = m_level_reg;
    assign m_drive_mode    = m_mode_reg;
    assign m_loop_position = m_pos_reg;
    assign m_recording     = m_rec_reg;

`ifndef SYNTH
    a_accept_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_BUSY) && !s_ready)
        else $error("transaction accepted but sequencer not busy");

    a_div_done_finishes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUSY && div_res.done) |=> (state_reg == ST_FINISH))
        else $error("divider finished but sequencer did not advance");

    a_mode_matches_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_level == '0) == (m_drive_mode == MODE_LOW)) &&
                    ((m_level == FULL_LEVEL) == (m_drive_mode == MODE_HIGH)))
        else $error("drive mode does not match level");
`endif

endmodule

`default_nettype wire
